// ----- hdl/iwr_pkg.sv -----
// Shared types, constants and CRC-32 helpers for the image word relocate block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package iwr_pkg;

   // Field widths
   localparam int ADDR_W   = 32;
   localparam int WORD_W   = 32;
   localparam int OFFSET_W = 24;
   localparam int NVALID_W = 3;
   localparam int SIZE_W   = 25;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_IS_B = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_A_BASE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_B_BASE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_BYTES  = 2'd3;

   // Configuration reset values
   localparam logic [ADDR_W-1:0] SLOT_A_BASE_RST = 32'h0801_0000;
   localparam logic [ADDR_W-1:0] SLOT_B_BASE_RST = 32'h0804_0000;
   localparam logic [SIZE_W-1:0] SLOT_BYTES_RST  = 25'h003_0000;

   // Image constants
   localparam int VECTOR_TABLE_BYTES_DEF = 256;
   localparam int WORD_BYTES = 4;
   localparam logic [7:0] PAD_BYTE = 8'hFF;

   // Reflected CRC-32
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // Decoupling queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Column j: contribution of bit j of {data, crc} to the next CRC
   typedef logic [2*WORD_W-1:0][31:0] crc_mat_type;

   typedef struct packed {
      logic              active_is_b;
      logic [ADDR_W-1:0] slot_a_base;
      logic [ADDR_W-1:0] slot_b_base;
      logic [SIZE_W-1:0] slot_bytes;
   } iwr_cfg_type;

   // Front pipeline register contents
   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [WORD_W-1:0] word;
      logic [WORD_W:0]   diff;       // word - slot_a_base, MSB is borrow
      logic              in_table;   // target B and inside relocatable table
      logic              enable;
      logic              target_is_b;
      logic              first;
      logic              last;
   } iwr_stage_type;

   // Queue entry handed from front to back
   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [WORD_W-1:0] word;
      logic              enable;
      logic              target_is_b;
      logic              first;
      logic              last;
   } iwr_entry_type;

   // Build the GF(2) update matrix by running the bit-serial CRC on unit vectors.
   // Evaluated at elaboration only.
   function automatic crc_mat_type crc_build_mat();
      crc_mat_type         mat;
      logic [2*WORD_W-1:0] v;
      logic [31:0]         crc;
      logic [31:0]         w;
      for (int j = 0; j < 2*WORD_W; j++) begin
         v   = '0;
         v[j] = 1'b1;
         crc = v[31:0];
         w   = v[2*WORD_W-1:WORD_W];
         for (int b = 0; b < WORD_BYTES; b++) begin
            crc = crc ^ {24'd0, w[8*b +: 8]};
            for (int k = 0; k < 8; k++) begin
               if (crc[0]) begin
                  crc = (crc >> 1) ^ CRC_POLY;
               end else begin
                  crc = crc >> 1;
               end
            end
         end
         mat[j] = crc;
      end
      return mat;
   endfunction

   localparam crc_mat_type CRC_MAT = crc_build_mat();

   // One-word CRC update as a flat XOR network
   function automatic logic [31:0] crc_apply(input logic [31:0] crc,
                                             input logic [WORD_W-1:0] data);
      logic [2*WORD_W-1:0] v;
      logic [31:0]         acc;
      v   = {data, crc};
      acc = '0;
      for (int j = 0; j < 2*WORD_W; j++) begin
         acc = acc ^ (CRC_MAT[j] & {32{v[j]}});
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/iwr_front.sv -----
// Front end: configuration registers, input acceptance, padding, bound check
// and vector table relocation. Depends on iwr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iwr_front import iwr_pkg::*; #(
   parameter int VECTOR_TABLE_BYTES = VECTOR_TABLE_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [OFFSET_W-1:0]   req_byte_offset,
   input  wire logic [WORD_W-1:0]     req_data_word,
   input  wire logic [NVALID_W-1:0]   req_valid_bytes,
   input  wire logic [SIZE_W-1:0]     req_chunk_end,
   input  wire logic                  req_first_of_image,
   input  wire logic                  req_last_of_image,
   output      logic                  push_valid,
   input  wire logic                  push_ready,
   output      iwr_entry_type         push_entry
);

   iwr_cfg_type   cfg_ff;
   iwr_stage_type stg_ff, stg_in;
   logic          stg_vld_ff, stg_vld_in;
   logic          take;
   logic [WORD_W-1:0] padded;
   logic          relocate;
   logic [WORD_W-1:0] moved;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_is_b <= 1'b0;
         cfg_ff.slot_a_base <= SLOT_A_BASE_RST;
         cfg_ff.slot_b_base <= SLOT_B_BASE_RST;
         cfg_ff.slot_bytes  <= SLOT_BYTES_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ACTIVE_IS_B: cfg_ff.active_is_b <= csr_wdata[0];
            CSR_SLOT_A_BASE: cfg_ff.slot_a_base <= csr_wdata[ADDR_W-1:0];
            CSR_SLOT_B_BASE: cfg_ff.slot_b_base <= csr_wdata[ADDR_W-1:0];
            CSR_SLOT_BYTES:  cfg_ff.slot_bytes  <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Pad bytes above the valid count
   always_comb begin
      unique case (req_valid_bytes)
         3'd0:    padded = {4{PAD_BYTE}};
         3'd1:    padded = {{3{PAD_BYTE}}, req_data_word[7:0]};
         3'd2:    padded = {{2{PAD_BYTE}}, req_data_word[15:0]};
         3'd3:    padded = {PAD_BYTE, req_data_word[23:0]};
         default: padded = req_data_word;
      endcase
   end

   // Stage one: address, bound check, window subtract
   assign req_ready = !stg_vld_ff || push_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      stg_in.target_is_b = !cfg_ff.active_is_b;
      stg_in.address     = (stg_in.target_is_b ? cfg_ff.slot_b_base : cfg_ff.slot_a_base)
                           + {{(ADDR_W-OFFSET_W){1'b0}}, req_byte_offset};
      stg_in.word        = padded;
      stg_in.diff        = {1'b0, padded} - {1'b0, cfg_ff.slot_a_base};
      stg_in.in_table    = stg_in.target_is_b
                           && (req_byte_offset < OFFSET_W'(VECTOR_TABLE_BYTES))
                           && (req_byte_offset >= OFFSET_W'(WORD_BYTES));
      stg_in.enable      = (req_chunk_end <= cfg_ff.slot_bytes);
      stg_in.first       = req_first_of_image;
      stg_in.last        = req_last_of_image;
      stg_vld_in         = take ? 1'b1 : (push_ready ? 1'b0 : stg_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= 1'b0;
      end else begin
         stg_vld_ff <= stg_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stg_ff <= stg_in;
      end
   end

   // Stage two: window compare and move into slot B
   assign relocate = stg_ff.in_table && !stg_ff.diff[WORD_W]
                     && (stg_ff.diff[WORD_W-1:SIZE_W] == '0)
                     && (stg_ff.diff[SIZE_W-1:0] < cfg_ff.slot_bytes);
   assign moved    = stg_ff.diff[WORD_W-1:0] + cfg_ff.slot_b_base;

   always_comb begin
      push_valid             = stg_vld_ff;
      push_entry.address     = stg_ff.address;
      push_entry.word        = relocate ? moved : stg_ff.word;
      push_entry.enable      = stg_ff.enable;
      push_entry.target_is_b = stg_ff.target_is_b;
      push_entry.first       = stg_ff.first;
      push_entry.last        = stg_ff.last;
   end

endmodule

`default_nettype wire

// ----- hdl/iwr_queue.sv -----
// Short queue between the front and back ends.
// Depends on iwr_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module iwr_queue import iwr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   output      logic          push_ready,
   input  wire iwr_entry_type push_entry,
   output      logic          pop_valid,
   input  wire logic          pop_ready,
   output      iwr_entry_type pop_entry
);

   iwr_entry_type         mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  push, pop;

   assign push_ready = (count_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QUEUE_CW'(push) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/iwr_back.sv -----
// Back end: running CRC-32 over written words and the result register.
// Depends on iwr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iwr_back import iwr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          pop_valid,
   output      logic          pop_ready,
   input  wire iwr_entry_type pop_entry,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   output      logic [ADDR_W-1:0] rsp_program_address,
   output      logic [WORD_W-1:0] rsp_program_word,
   output      logic          rsp_program_enable,
   output      logic          rsp_target_is_b,
   output      logic [31:0]   rsp_crc_value,
   output      logic          rsp_crc_ready
);

   logic [31:0] acc_ff, acc_in;
   logic [31:0] crc_base, crc_upd;
   logic        rsp_vld_ff, rsp_vld_in;
   logic        take;

   assign pop_ready = !rsp_vld_ff || rsp_ready;
   assign take      = pop_valid && pop_ready;
   assign rsp_valid = rsp_vld_ff;

   // CRC update; rejected words do not change the CRC, but a rejected first word still restarts it
   always_comb begin
      crc_base   = pop_entry.first ? CRC_INIT : acc_ff;
      crc_upd    = crc_apply(crc_base, pop_entry.word);
      acc_in     = pop_entry.enable ? crc_upd : crc_base;
      rsp_vld_in = take ? 1'b1 : (rsp_ready ? 1'b0 : rsp_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= CRC_INIT;
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
         if (take) begin
            acc_ff <= acc_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_program_address <= pop_entry.address;
         rsp_program_word    <= pop_entry.word;
         rsp_program_enable  <= pop_entry.enable;
         rsp_target_is_b     <= pop_entry.target_is_b;
         rsp_crc_value       <= pop_entry.last ? ~acc_in : '0;
         rsp_crc_ready       <= pop_entry.last;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/image_word_relocate_and_crc32.sv -----
// An accepted word passes the front register, then the queue, then the result register, where
// it is offered as a result. Throughput: one word per cycle while the receiver keeps taking
// results, with the 32-bit CRC update done combinationally in the back end. Synchronous
// active-high reset clears all control state, loads the default slot configuration and
// sets the CRC to all ones.
// Top level; depends on iwr_pkg, iwr_front, iwr_queue and iwr_back.
`timescale 1ns / 1ps
`default_nettype none

module image_word_relocate_and_crc32 import iwr_pkg::*; #(
   parameter int VECTOR_TABLE_BYTES = VECTOR_TABLE_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [OFFSET_W-1:0]   req_byte_offset,
   input  wire logic [WORD_W-1:0]     req_data_word,
   input  wire logic [NVALID_W-1:0]   req_valid_bytes,
   input  wire logic [SIZE_W-1:0]     req_chunk_end,
   input  wire logic                  req_first_of_image,
   input  wire logic                  req_last_of_image,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [ADDR_W-1:0]     rsp_program_address,
   output      logic [WORD_W-1:0]     rsp_program_word,
   output      logic                  rsp_program_enable,
   output      logic                  rsp_target_is_b,
   output      logic [31:0]           rsp_crc_value,
   output      logic                  rsp_crc_ready
);

   logic          push_valid, push_ready;
   iwr_entry_type push_entry;
   logic          pop_valid, pop_ready;
   iwr_entry_type pop_entry;

   iwr_front #(
      .VECTOR_TABLE_BYTES(VECTOR_TABLE_BYTES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_byte_offset    (req_byte_offset),
      .req_data_word      (req_data_word),
      .req_valid_bytes    (req_valid_bytes),
      .req_chunk_end      (req_chunk_end),
      .req_first_of_image (req_first_of_image),
      .req_last_of_image  (req_last_of_image),
      .push_valid         (push_valid),
      .push_ready         (push_ready),
      .push_entry         (push_entry)
   );

   iwr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   iwr_back u_back (
      .clock               (clock),
      .reset               (reset),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_entry           (pop_entry),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_program_address (rsp_program_address),
      .rsp_program_word    (rsp_program_word),
      .rsp_program_enable  (rsp_program_enable),
      .rsp_target_is_b     (rsp_target_is_b),
      .rsp_crc_value       (rsp_crc_value),
      .rsp_crc_ready       (rsp_crc_ready)
   );

endmodule

`default_nettype wire

// ----- hdl/iwr_checker.sv -----
// Port-level checks for the image word relocate block, bound to the top level.
// Depends on iwr_pkg and image_word_relocate_and_crc32.
`timescale 1ns / 1ps
`default_nettype none

module iwr_checker import iwr_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [ADDR_W-1:0] rsp_program_address,
   input wire logic [WORD_W-1:0] rsp_program_word,
   input wire logic [31:0]       rsp_crc_value,
   input wire logic              rsp_crc_ready
);

   // A pending result transfer is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_program_address) && $stable(rsp_program_word)
         && $stable(rsp_crc_value) && $stable(rsp_crc_ready))
      else $error("stalled result changed");

   // CRC is only reported on the last word
   a_crc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_crc_ready |-> rsp_crc_value == '0)
      else $error("crc value set without crc_ready");

   // Nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind image_word_relocate_and_crc32 iwr_checker u_iwr_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_program_address (rsp_program_address),
   .rsp_program_word    (rsp_program_word),
   .rsp_crc_value       (rsp_crc_value),
   .rsp_crc_ready       (rsp_crc_ready)
);

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for image_word_relocate_and_crc32.
// Depends on iwr_pkg and the block's top level; has its own prediction of
// padding, vector table relocation, slot bound check and CRC-32.
`timescale 1ns / 1ps

module tb_top;
   import iwr_pkg::*;

   localparam int LIMIT_CYCLES = 300000;
   localparam int VT_BYTES     = VECTOR_TABLE_BYTES_DEF;
   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      logic [OFFSET_W-1:0] byte_offset;
      logic [WORD_W-1:0]   data_word;
      logic [NVALID_W-1:0] valid_bytes;
      logic [SIZE_W-1:0]   chunk_end;
      logic                first_word;
      logic                last_word;
   } image_word_type;

   typedef struct {
      logic [ADDR_W-1:0] address;
      logic [WORD_W-1:0] word;
      logic              enable;
      logic              target_b;
      logic [31:0]       crc;
      logic              crc_rdy;
   } program_req_type;

   typedef struct {
      image_word_type  stim;
      bit              fixed;
      program_req_type result;
   } directed_row_type;

   // DUT ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [OFFSET_W-1:0]   req_byte_offset = '0;
   logic [WORD_W-1:0]     req_data_word = '0;
   logic [NVALID_W-1:0]   req_valid_bytes = '0;
   logic [SIZE_W-1:0]     req_chunk_end = '0;
   logic                  req_first_of_image = 1'b0;
   logic                  req_last_of_image = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [ADDR_W-1:0]     rsp_program_address;
   logic [WORD_W-1:0]     rsp_program_word;
   logic                  rsp_program_enable;
   logic                  rsp_target_is_b;
   logic [31:0]           rsp_crc_value;
   logic                  rsp_crc_ready;

   // Shadow of the slot configuration and the running CRC
   logic              cfg_active_b = 1'b0;
   logic [ADDR_W-1:0] cfg_a_base   = SLOT_A_BASE_RST;
   logic [ADDR_W-1:0] cfg_b_base   = SLOT_B_BASE_RST;
   logic [SIZE_W-1:0] cfg_slot     = SLOT_BYTES_RST;
   logic [31:0]       crc_acc      = CRC_INIT;

   program_req_type  pending_programs[$];
   directed_row_type directed[$];

   // Typed expectation for the word currently offered, if any
   bit               fixed_pending;
   program_req_type  fixed_result;

   int cycle_count;
   int mismatches;
   int words_sent;
   int results_checked;
   int rejects_seen;
   int relocations_seen;
   int images_closed;
   int burst_left;

   image_word_relocate_and_crc32 u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_byte_offset     (req_byte_offset),
      .req_data_word       (req_data_word),
      .req_valid_bytes     (req_valid_bytes),
      .req_chunk_end       (req_chunk_end),
      .req_first_of_image  (req_first_of_image),
      .req_last_of_image   (req_last_of_image),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_program_address (rsp_program_address),
      .rsp_program_word    (rsp_program_word),
      .rsp_program_enable  (rsp_program_enable),
      .rsp_target_is_b     (rsp_target_is_b),
      .rsp_crc_value       (rsp_crc_value),
      .rsp_crc_ready       (rsp_crc_ready)
   );

   always #5 clock = ~clock;

   // Reflected CRC-32, one bit at a time, low bit of the word first
   function automatic logic [31:0] crc32_update(input logic [31:0] crc,
                                                input logic [31:0] data);
      logic [31:0] c;
      c = crc;
      for (int i = 0; i < 32; i++) begin
         if (c[0] ^ data[i]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // Expected program request for one word; advances the shadow CRC
   function automatic program_req_type program_request_for(input image_word_type w);
      program_req_type r;
      logic [31:0]     word;
      logic [31:0]     diff;
      logic            to_b;
      int              nvalid;
      nvalid = (w.valid_bytes > 4) ? 4 : int'(w.valid_bytes);
      word = w.data_word;
      if (nvalid < 4) begin
         word = word | (32'hFFFF_FFFF << (8 * nvalid));
      end
      to_b = !cfg_active_b;
      // pointers into slot A inside the vector table, stack pointer excluded
      if (to_b && w.byte_offset < VT_BYTES && w.byte_offset >= 4) begin
         diff = word - cfg_a_base;
         if (word >= cfg_a_base && diff < {7'd0, cfg_slot}) begin
            word = diff + cfg_b_base;
            relocations_seen++;
         end
      end
      r.enable = (w.chunk_end <= cfg_slot);
      if (!r.enable) rejects_seen++;
      if (w.first_word) crc_acc = CRC_INIT;
      if (r.enable) crc_acc = crc32_update(crc_acc, word);
      r.crc      = w.last_word ? ~crc_acc : 32'd0;
      r.crc_rdy  = w.last_word;
      r.address  = (to_b ? cfg_b_base : cfg_a_base) + {8'd0, w.byte_offset};
      r.word     = word;
      r.target_b = to_b;
      return r;
   endfunction

   function automatic directed_row_type make_row(
      input logic [OFFSET_W-1:0] off, input logic [WORD_W-1:0] data,
      input logic [NVALID_W-1:0] nvalid, input logic [SIZE_W-1:0] cend,
      input logic first_word, input logic last_word, input bit fixed,
      input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] word,
      input logic enable);
      directed_row_type d;
      d.stim = '{off, data, nvalid, cend, first_word, last_word};
      d.fixed = fixed;
      // typed rows all run under the reset setting: target is slot B
      d.result = '{addr, word, enable, 1'b1, 32'd0, 1'b0};
      return d;
   endfunction

   // Timeout
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_programs.size());
      $display("FAILED: results differ");
      $finish;
   end

   // Receiver: ready pattern switches at random among four modes
   int rx_mode;
   int rx_left = 0;
   int rx_tick = 0;
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (rx_tick % 3 != 0);
      endcase
   end

   // Monitor: register writes, accepted words, returned requests
   always @(posedge clock) begin
      image_word_type  w;
      program_req_type exp;
      program_req_type got;
      program_req_type predicted;
      bit              bad;
      if (reset) begin
         cfg_active_b = 1'b0;
         cfg_a_base   = SLOT_A_BASE_RST;
         cfg_b_base   = SLOT_B_BASE_RST;
         cfg_slot     = SLOT_BYTES_RST;
         crc_acc      = CRC_INIT;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ACTIVE_IS_B: cfg_active_b = csr_wdata[0];
               CSR_SLOT_A_BASE: cfg_a_base   = csr_wdata;
               CSR_SLOT_B_BASE: cfg_b_base   = csr_wdata;
               CSR_SLOT_BYTES:  cfg_slot     = csr_wdata[SIZE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            w = '{req_byte_offset, req_data_word, req_valid_bytes, req_chunk_end,
                  req_first_of_image, req_last_of_image};
            predicted = program_request_for(w);
            pending_programs.push_back(fixed_pending ? fixed_result : predicted);
            words_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_program_address, rsp_program_word, rsp_program_enable,
                    rsp_target_is_b, rsp_crc_value, rsp_crc_ready};
            if (pending_programs.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result at cycle %0d: addr %h word %h",
                           cycle_count, got.address, got.word);
            end else begin
               exp = pending_programs.pop_front();
               results_checked++;
               if (got.crc_rdy === 1'b1) images_closed++;
               bad = (got.address !== exp.address) || (got.word !== exp.word) ||
                     (got.enable !== exp.enable) || (got.target_b !== exp.target_b) ||
                     (got.crc !== exp.crc) || (got.crc_rdy !== exp.crc_rdy);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $write("mismatch at cycle %0d (exp/act): addr %h/%h word %h/%h",
                            cycle_count, exp.address, got.address, exp.word, got.word);
                     $display(" en %b/%b tgt_b %b/%b crc %h/%h rdy %b/%b",
                              exp.enable, got.enable, exp.target_b, got.target_b,
                              exp.crc, got.crc, exp.crc_rdy, got.crc_rdy);
                  end
               end
            end
         end
      end
   end

   // Offer one word; bursts of random length separated by random gaps
   task automatic drive_word(input image_word_type w, input bit fixed,
                             input program_req_type result);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      fixed_pending = fixed;
      fixed_result  = result;
      req_valid          <= 1'b1;
      req_byte_offset    <= w.byte_offset;
      req_data_word      <= w.data_word;
      req_valid_bytes    <= w.valid_bytes;
      req_chunk_end      <= w.chunk_end;
      req_first_of_image <= w.first_word;
      req_last_of_image  <= w.last_word;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Hold the sender until every outstanding request has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (pending_programs.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // Slot settings per phase, extremes included; writes happen while idle
   task automatic apply_phase(input int phase);
      case (phase)
         1: begin
            write_csr(CSR_ACTIVE_IS_B, 32'd1);
         end
         2: begin
            write_csr(CSR_ACTIVE_IS_B, 32'd0);
            write_csr(CSR_SLOT_A_BASE, 32'h0000_0000);
            write_csr(CSR_SLOT_B_BASE, 32'hFFFF_FFFF);
            write_csr(CSR_SLOT_BYTES, 32'h0100_0000);
         end
         3: begin
            // zero slot size: only a zero chunk end fits, nothing relocates
            write_csr(CSR_SLOT_BYTES, 32'h0000_0000);
         end
         4: begin
            write_csr(CSR_SLOT_A_BASE, $urandom);
            write_csr(CSR_SLOT_BYTES, 32'd1);
         end
         5: begin
            // upper data bits above the register width are ignored
            write_csr(CSR_ACTIVE_IS_B, $urandom | 32'd1);
            write_csr(CSR_SLOT_A_BASE, 32'hFFFF_FFFF);
            write_csr(CSR_SLOT_B_BASE, 32'h0000_0000);
            write_csr(CSR_SLOT_BYTES, 32'hFFFF_FFFF);
         end
         6: begin
            write_csr(CSR_ACTIVE_IS_B, $urandom & ~32'd1);
            write_csr(CSR_SLOT_A_BASE, $urandom);
            write_csr(CSR_SLOT_B_BASE, $urandom);
            write_csr(CSR_SLOT_BYTES, $urandom_range(64, 4096) | 32'hFE00_0000);
         end
         7: begin
            write_csr(CSR_SLOT_A_BASE, SLOT_A_BASE_RST);
            write_csr(CSR_SLOT_B_BASE, SLOT_B_BASE_RST);
            write_csr(CSR_SLOT_BYTES, 32'd96);
         end
         default: begin
            write_csr(CSR_ACTIVE_IS_B, $urandom_range(0, 1));
            write_csr(CSR_SLOT_A_BASE, $urandom);
            write_csr(CSR_SLOT_B_BASE, $urandom);
            write_csr(CSR_SLOT_BYTES, $urandom_range(1, 32'h0100_0000));
         end
      endcase
      csr_wr_en <= 1'b0;
   endtask

   // Image word content: near slot A bounds inside the vector table
   function automatic logic [31:0] pick_word(input int off);
      if (off < VT_BYTES && $urandom_range(0, 2) != 0) begin
         case ($urandom_range(0, 4))
            0: return cfg_a_base;
            1: return cfg_a_base - 32'd1;
            2: return cfg_a_base + {7'd0, cfg_slot};
            3: return cfg_a_base + {7'd0, cfg_slot} - 32'd1;
            default: return cfg_a_base +
                            ((cfg_slot == 0) ? 32'd0 : $urandom_range(0, cfg_slot - 1));
         endcase
      end
      return $urandom;
   endfunction

   // Mostly in-order images with random content, some noise and broken ones
   task automatic random_items(input int count);
      program_req_type none;
      image_word_type  w;
      int sent, nwords, lastvalid, csize, start, total, off, cstart, cend;
      none = '{default: '0};
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 2) begin
            w.byte_offset = ($urandom_range(0, 1) == 0) ? OFFSET_W'($urandom)
                                                        : OFFSET_W'($urandom_range(0, 255));
            w.data_word   = $urandom;
            w.valid_bytes = NVALID_W'($urandom_range(0, 7));
            w.chunk_end   = SIZE_W'($urandom);
            w.first_word  = 1'($urandom_range(0, 1));
            w.last_word   = 1'($urandom_range(0, 1));
            drive_word(w, 1'b0, none);
            sent++;
         end else begin
            nwords    = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80)
                                                    : $urandom_range(1, 20);
            lastvalid = $urandom_range(1, 4);
            csize     = 4 * $urandom_range(1, 16);
            total     = 4 * (nwords - 1) + lastvalid;
            start     = 0;
            if ($urandom_range(0, 5) == 0) begin
               // image placed to run over the end of the slot
               start = int'(cfg_slot) - 4 * int'($urandom_range(0, 8));
               if (start < 0) start = 0;
               start = start & ~3;
            end
            for (int k = 0; k < nwords; k++) begin
               off    = 4 * k;
               cstart = (off / csize) * csize;
               cend   = cstart + csize;
               if (cend > total) cend = total;
               w.byte_offset = OFFSET_W'(start + off);
               w.data_word   = pick_word(start + off);
               w.valid_bytes = NVALID_W'((k == nwords - 1) ? lastvalid : 4);
               w.chunk_end   = SIZE_W'(start + cend);
               w.first_word  = (k == 0) && ($urandom_range(0, 7) != 0);
               w.last_word   = (k == nwords - 1) && ($urandom_range(0, 7) != 0);
               drive_word(w, 1'b0, none);
               sent++;
            end
            if ($urandom_range(0, 39) == 0) drain_results();
         end
      end
   endtask

   initial begin
      // under the reset setting: slot A at 0x0801_0000, B at 0x0804_0000, 192 KiB
      directed.push_back(make_row(24'h0,  32'h2002_0000, 3'd4, 25'h10, 1'b1, 1'b0, 1'b1,
                                  32'h0804_0000, 32'h2002_0000, 1'b1));
      directed.push_back(make_row(24'h4,  32'h0801_0401, 3'd4, 25'h10, 1'b0, 1'b0, 1'b1,
                                  32'h0804_0004, 32'h0804_0401, 1'b1));
      directed.push_back(make_row(24'h8,  32'h0803_FFFF, 3'd4, 25'h10, 1'b0, 1'b0, 1'b1,
                                  32'h0804_0008, 32'h0806_FFFF, 1'b1));
      directed.push_back(make_row(24'hC,  32'h0804_0000, 3'd4, 25'h10, 1'b0, 1'b0, 1'b1,
                                  32'h0804_000C, 32'h0804_0000, 1'b1));
      directed.push_back(make_row(24'h10, 32'h0800_FFFF, 3'd4, 25'h20, 1'b0, 1'b0, 1'b1,
                                  32'h0804_0010, 32'h0800_FFFF, 1'b1));
      directed.push_back(make_row(24'h14, 32'h0801_0000, 3'd4, 25'h20, 1'b0, 1'b0, 1'b1,
                                  32'h0804_0014, 32'h0804_0000, 1'b1));
      directed.push_back(make_row(24'hFC, 32'h0801_1234, 3'd4, 25'h100, 1'b0, 1'b0, 1'b1,
                                  32'h0804_00FC, 32'h0804_1234, 1'b1));
      directed.push_back(make_row(24'h100, 32'h0801_1234, 3'd4, 25'h110, 1'b0, 1'b0, 1'b1,
                                  32'h0804_0100, 32'h0801_1234, 1'b1));
      directed.push_back(make_row(24'h104, 32'h0000_0012, 3'd1, 25'h110, 1'b0, 1'b0, 1'b1,
                                  32'h0804_0104, 32'hFFFF_FF12, 1'b1));
      directed.push_back(make_row(24'h108, 32'h0000_BEEF, 3'd2, 25'h110, 1'b0, 1'b0, 1'b1,
                                  32'h0804_0108, 32'hFFFF_BEEF, 1'b1));
      directed.push_back(make_row(24'h10C, 32'h00AB_CDEF, 3'd3, 25'h110, 1'b0, 1'b0, 1'b1,
                                  32'h0804_010C, 32'hFFAB_CDEF, 1'b1));
      directed.push_back(make_row(24'h110, 32'h1234_5678, 3'd0, 25'h120, 1'b0, 1'b0, 1'b1,
                                  32'h0804_0110, 32'hFFFF_FFFF, 1'b1));
      directed.push_back(make_row(24'h114, 32'hA5A5_A5A5, 3'd7, 25'h120, 1'b0, 1'b0, 1'b1,
                                  32'h0804_0114, 32'hA5A5_A5A5, 1'b1));
      directed.push_back(make_row(24'h118, 32'h0000_0000, 3'd4, 25'h120, 1'b0, 1'b1, 1'b0,
                                  '0, '0, 1'b0));
      directed.push_back(make_row(24'h2FFFC, 32'h5A5A_5A5A, 3'd4, 25'h30000,
                                  1'b1, 1'b0, 1'b1,
                                  32'h0806_FFFC, 32'h5A5A_5A5A, 1'b1));
      directed.push_back(make_row(24'h30000, 32'h1122_3344, 3'd4, 25'h30001,
                                  1'b0, 1'b0, 1'b1,
                                  32'h0807_0000, 32'h1122_3344, 1'b0));
      directed.push_back(make_row(24'hFF_FFFF, 32'hFFFF_FFFF, 3'd4, 25'h1FF_FFFF,
                                  1'b0, 1'b0, 1'b1,
                                  32'h0903_FFFF, 32'hFFFF_FFFF, 1'b0));
      // rejected last word still reports the CRC so far
      directed.push_back(make_row(24'h30004, 32'h0000_0001, 3'd4, 25'h30008,
                                  1'b0, 1'b1, 1'b0,
                                  '0, '0, 1'b0));
      // no restart: the accumulator carries over past a last word
      directed.push_back(make_row(24'h0, 32'h0000_0000, 3'd4, 25'h0, 1'b0, 1'b1, 1'b0,
                                  '0, '0, 1'b0));
      directed.push_back(make_row(24'h0, 32'h0801_0400, 3'd4, 25'h4, 1'b1, 1'b1, 1'b0,
                                  '0, '0, 1'b0));
      directed.push_back(make_row(24'h4, 32'hFFFF_FFFF, 3'd4, 25'h8, 1'b1, 1'b1, 1'b0,
                                  '0, '0, 1'b0));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) drive_word(directed[i].stim, directed[i].fixed,
                                       directed[i].result);
      drain_results();
      random_items(100);
      drain_results();
      for (int phase = 1; phase <= 8; phase++) begin
         apply_phase(phase);
         random_items(100);
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (pending_programs.size() != 0) mismatches++;

      $display("%0d words transferred over 9 slot settings, %0d requests checked",
               words_sent, results_checked);
      $display("%0d out-of-bound rejects, %0d relocated pointers, %0d final CRCs",
               rejects_seen, relocations_seen, images_closed);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
